// ----- src/pee_pkg.sv -----
// Shared types, opcodes and status codes of the postfix expression evaluator.
`default_nettype none

package pee_pkg;

  localparam int VAL_W = 16;
  localparam int OP_W  = 4;
  localparam int ST_W  = 3;

  localparam logic [OP_W-1:0] OP_PUSH = 4'd0;
  localparam logic [OP_W-1:0] OP_MUL  = 4'd1;
  localparam logic [OP_W-1:0] OP_DIV  = 4'd2;
  localparam logic [OP_W-1:0] OP_ADD  = 4'd3;
  localparam logic [OP_W-1:0] OP_SUB  = 4'd4;
  localparam logic [OP_W-1:0] OP_AND  = 4'd5;
  localparam logic [OP_W-1:0] OP_OR   = 4'd6;
  localparam logic [OP_W-1:0] OP_XOR  = 4'd7;
  localparam logic [OP_W-1:0] OP_SHL  = 4'd8;
  localparam logic [OP_W-1:0] OP_SHR  = 4'd9;
  localparam logic [OP_W-1:0] OP_NOT  = 4'd10;
  localparam logic [OP_W-1:0] OP_NEG  = 4'd11;

  localparam logic [ST_W-1:0] ST_OK    = 3'd0;
  localparam logic [ST_W-1:0] ST_UNDER = 3'd1;
  localparam logic [ST_W-1:0] ST_OVER  = 3'd2;
  localparam logic [ST_W-1:0] ST_DIVZ  = 3'd3;
  localparam logic [ST_W-1:0] ST_COUNT = 3'd4;

  typedef struct packed {
    logic             full;
    logic [VAL_W-1:0] value;
  } entry_t;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [VAL_W-1:0] value;
    logic             full_req;
    logic             last;
  } token_t;

endpackage

`default_nettype wire

// ----- src/pee_if.sv -----
// Token and result channel interfaces of the postfix expression evaluator.
`default_nettype none

interface pee_in_if;
  logic                      valid;
  logic                      ready;
  logic [pee_pkg::OP_W-1:0]  op;
  logic [pee_pkg::VAL_W-1:0] value;
  logic                      full_req;
  logic                      last;

  modport source (output valid, input ready, output op, output value, output full_req,
                  output last);
  modport sink   (input valid, output ready, input op, input value, input full_req,
                  input last);
endinterface

interface pee_out_if;
  logic                      valid;
  logic                      ready;
  logic [pee_pkg::VAL_W-1:0] result;
  logic                      result_full;
  logic [pee_pkg::ST_W-1:0]  status;

  modport source (output valid, input ready, output result, output result_full,
                  output status);
  modport sink   (input valid, output ready, input result, input result_full,
                  input status);
endinterface

`default_nettype wire

// ----- src/pee_alu.sv -----
// Combinational arithmetic and logic unit for all operators except divide.
`default_nettype none

module pee_alu (
  input  logic [pee_pkg::OP_W-1:0] op_i,
  input  pee_pkg::entry_t          a_i,
  input  pee_pkg::entry_t          b_i,
  output pee_pkg::entry_t          res_o
);
  import pee_pkg::*;

  logic [2*VAL_W-1:0] prod;
  logic               wide_shift;
  logic [VAL_W-1:0]   r;

  assign prod       = a_i.value * b_i.value;
  assign wide_shift = |b_i.value[VAL_W-1:4];

  always_comb begin
    r          = '0;
    res_o.full = a_i.full | b_i.full;
    case (op_i)
      OP_MUL: r = prod[VAL_W-1:0];
      OP_ADD: r = a_i.value + b_i.value;
      OP_SUB: r = a_i.value - b_i.value;
      OP_AND: r = a_i.value & b_i.value;
      OP_OR:  r = a_i.value | b_i.value;
      OP_XOR: r = a_i.value ^ b_i.value;
      OP_SHL: r = wide_shift ? '0 : (a_i.value << b_i.value[3:0]);
      OP_SHR: r = wide_shift ? '0 : (a_i.value >> b_i.value[3:0]);
      OP_NOT, OP_NEG: begin
        // unary operators work on the top entry and keep its flag
        r          = (op_i == OP_NOT) ? ~b_i.value : (VAL_W'(0) - b_i.value);
        res_o.full = b_i.full;
        if (!b_i.full) begin
          r = {8'h00, r[7:0]};
        end
      end
      default: r = '0;
    endcase
    res_o.value = r;
  end

endmodule

`default_nettype wire

// ----- src/pee_div.sv -----
// Restoring divider, one quotient bit per cycle.
`default_nettype none

module pee_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start_i,
  input  logic [pee_pkg::VAL_W-1:0]  dividend_i,
  input  logic [pee_pkg::VAL_W-1:0]  divisor_i,
  output logic                       done_o,
  output logic [pee_pkg::VAL_W-1:0]  quotient_o
);
  import pee_pkg::*;

  localparam int CW = $clog2(VAL_W + 1);

  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [VAL_W-1:0] rem_r, rem_nxt;
  logic [VAL_W-1:0] quo_r, quo_nxt;
  logic [VAL_W-1:0] dsr_r;
  logic [VAL_W+1:0] diff;
  logic             ge;

  assign diff    = {1'b0, rem_r, quo_r[VAL_W-1]} - {2'b00, dsr_r};
  assign ge      = ~diff[VAL_W+1];
  assign rem_nxt = ge ? diff[VAL_W-1:0] : {rem_r[VAL_W-2:0], quo_r[VAL_W-1]};
  assign quo_nxt = {quo_r[VAL_W-2:0], ge};

  always_comb begin
    cnt_nxt = cnt_r;
    if (start_i) begin
      cnt_nxt = CW'(VAL_W);
    end else if (cnt_r != '0) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  // last step completes at the edge where the count leaves one
  assign done_o     = (cnt_r == CW'(1));
  assign quotient_o = quo_nxt;

  always_ff @(posedge clk) begin
    if (start_i) begin
      rem_r <= '0;
      quo_r <= dividend_i;
      dsr_r <= divisor_i;
    end else if (cnt_r != '0) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- src/postfix_expression_evaluator_top.sv -----
// Top level of the postfix expression evaluator: sequencer, stack memory and result register.
//
//  channel | dir | handshake     | payload
//  --------+-----+---------------+----------------------------------
//  in_ch   | in  | valid / ready | op, value, full_req, last
//  out_ch  | out | valid / ready | result, result_full, status
//
// A token passes through the accept, stack read, execute and finish steps; a divide
// also waits in the divide step, where the divider retires one quotient bit per cycle.
// A last token waits in the finish step until the result register is free.
// Reset is synchronous and clears the sequencer, stack pointer, error code and output valid.
// in_ch.ready is high only while the sequencer is idle.
`default_nettype none

module postfix_expression_evaluator_top #(
  parameter int STACK_DEPTH = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  pee_in_if.sink   in_ch,
  pee_out_if.source out_ch
);
  import pee_pkg::*;

  localparam int PW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EXEC,
    S_DIV,
    S_FIN
  } state_t;

  state_t           state_r, state_nxt;
  logic [PW-1:0]    sp_r, sp_nxt;
  logic [ST_W-1:0]  err_r, err_nxt;
  token_t           tok_r, tok_nxt;
  entry_t           top_r, top_nxt;
  entry_t           rd_r;
  logic             out_valid_r, out_valid_nxt;
  logic [VAL_W-1:0] out_result_r, out_result_nxt;
  logic             out_full_r, out_full_nxt;
  logic [ST_W-1:0]  out_status_r, out_status_nxt;

  entry_t           stack_mem [STACK_DEPTH];
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  entry_t           mem_wdata;
  logic [PW-1:0]    sp_m1, sp_m2;
  logic [AW-1:0]    rd_addr;

  entry_t           alu_res;
  logic             div_start;
  logic             div_done;
  logic [VAL_W-1:0] div_quo;
  logic             out_free;
  logic [ST_W-1:0]  fin_status;

  assign sp_m1   = sp_r - PW'(1);
  assign sp_m2   = sp_r - PW'(2);
  assign rd_addr = sp_m2[AW-1:0];

  pee_alu u_alu (
    .op_i  (tok_r.op),
    .a_i   (rd_r),
    .b_i   (top_r),
    .res_o (alu_res)
  );

  pee_div u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .start_i    (div_start),
    .dividend_i (rd_r.value),
    .divisor_i  (top_r.value),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // second entry from the top; the top itself is held in top_r
  always_ff @(posedge clk) begin
    if (mem_we) begin
      stack_mem[mem_waddr] <= mem_wdata;
    end
    rd_r <= stack_mem[rd_addr];
  end

  assign in_ch.ready = (state_r == S_IDLE);
  assign out_free    = ~out_valid_r | out_ch.ready;
  assign fin_status  = (err_r != ST_OK) ? err_r :
                       ((sp_r != PW'(1)) ? ST_COUNT : ST_OK);

  always_comb begin
    state_nxt      = state_r;
    sp_nxt         = sp_r;
    err_nxt        = err_r;
    tok_nxt        = tok_r;
    top_nxt        = top_r;
    out_valid_nxt  = out_valid_r & ~out_ch.ready;
    out_result_nxt = out_result_r;
    out_full_nxt   = out_full_r;
    out_status_nxt = out_status_r;
    mem_we         = 1'b0;
    mem_waddr      = sp_m2[AW-1:0];
    mem_wdata      = alu_res;
    div_start      = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          tok_nxt   = '{op: in_ch.op, value: in_ch.value, full_req: in_ch.full_req,
                        last: in_ch.last};
          state_nxt = S_READ;
        end
      end
      S_READ: state_nxt = S_EXEC;
      S_EXEC: begin
        state_nxt = S_FIN;
        if (err_r == ST_OK) begin
          case (tok_r.op)
            OP_PUSH: begin
              if (sp_r == PW'(STACK_DEPTH)) begin
                err_nxt = ST_OVER;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = sp_r[AW-1:0];
                mem_wdata = '{full: tok_r.full_req, value: tok_r.value};
                top_nxt   = mem_wdata;
                sp_nxt    = sp_r + PW'(1);
              end
            end
            OP_NOT, OP_NEG: begin
              if (sp_r == '0) begin
                err_nxt = ST_UNDER;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = sp_m1[AW-1:0];
                top_nxt   = alu_res;
              end
            end
            OP_DIV: begin
              if (sp_r < PW'(2)) begin
                err_nxt = ST_UNDER;
              end else if (top_r.value == '0) begin
                err_nxt = ST_DIVZ;
              end else begin
                div_start = 1'b1;
                state_nxt = S_DIV;
              end
            end
            OP_MUL, OP_ADD, OP_SUB, OP_AND, OP_OR, OP_XOR, OP_SHL, OP_SHR: begin
              if (sp_r < PW'(2)) begin
                err_nxt = ST_UNDER;
              end else begin
                mem_we  = 1'b1;
                top_nxt = alu_res;
                sp_nxt  = sp_m1;
              end
            end
            default: ;
          endcase
        end
      end
      S_DIV: begin
        if (div_done) begin
          mem_we    = 1'b1;
          mem_wdata = '{full: rd_r.full | top_r.full, value: div_quo};
          top_nxt   = mem_wdata;
          sp_nxt    = sp_m1;
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!tok_r.last) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          // emit, then clear the stack for the next expression
          out_valid_nxt  = 1'b1;
          out_status_nxt = fin_status;
          out_result_nxt = (fin_status == ST_OK) ? top_r.value : '0;
          out_full_nxt   = (fin_status == ST_OK) ? top_r.full : 1'b0;
          sp_nxt         = '0;
          err_nxt        = ST_OK;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    tok_r        <= tok_nxt;
    top_r        <= top_nxt;
    out_result_r <= out_result_nxt;
    out_full_r   <= out_full_nxt;
    out_status_r <= out_status_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sp_r        <= '0;
      err_r       <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sp_r        <= sp_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.result      = out_result_r;
  assign out_ch.result_full = out_full_r;
  assign out_ch.status      = out_status_r;

`ifndef ASSERT_OFF
  a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= PW'(STACK_DEPTH))
    else $error("stack pointer beyond stack depth");

  a_err_result_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status != ST_OK) |-> (out_ch.result == '0 && !out_ch.result_full))
    else $error("failed expression carries a nonzero result");

  a_clear_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && tok_r.last && out_free) |=> (sp_r == '0 && err_r == ST_OK
      && out_ch.valid))
    else $error("stack not cleared after result transfer");

  a_div_in_div_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_DIV)
    else $error("divider finished outside divide step");
`endif

endmodule

`default_nettype wire

// ----- test/tb_top.sv -----
// Self-checking testbench for the postfix expression evaluator: directed table and random tokens.
`default_nettype none

module tb_top;
  import pee_pkg::*;

  localparam int MODEL_DEPTH    = 16;
  localparam int RANDOM_TOKENS  = 1400;
  localparam int PHASE_TOKENS   = 175;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES    = 40;

  // opcodes the block treats as no-ops
  localparam logic [OP_W-1:0] OP_SPARE_LO = 4'd12;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 4'd15;

  typedef struct packed {
    logic [VAL_W-1:0] result;
    logic             full;
    logic [ST_W-1:0]  status;
  } outcome_t;

  typedef struct {
    token_t   tok;
    bit       typed;
    outcome_t want;
  } table_row_t;

  logic clk;
  logic rst_n;

  pee_in_if  in_ch ();
  pee_out_if out_ch ();

  postfix_expression_evaluator_top #(.STACK_DEPTH(MODEL_DEPTH)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // stack model of the evaluator
  logic [VAL_W-1:0] stack_vals [MODEL_DEPTH];
  logic             stack_flags [MODEL_DEPTH];
  int               stack_count = 0;
  logic [ST_W-1:0]  expr_error  = ST_OK;

  outcome_t   pending_results [$];
  table_row_t directed_rows [$];
  token_t     burst [$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int fail_count     = 0;
  int quiet_cycles   = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Apply one token to the model; return 1 when it closes an expression.
  function automatic bit evaluate_token(input token_t t, output outcome_t r);
    logic [VAL_W-1:0] a, b, q;
    logic             fa, fb;
    r = '0;
    if (expr_error == ST_OK) begin
      if (t.op == OP_PUSH) begin
        if (stack_count >= MODEL_DEPTH) begin
          expr_error = ST_OVER;
        end else begin
          stack_vals[stack_count]  = t.value;
          stack_flags[stack_count] = t.full_req;
          stack_count++;
        end
      end else if (t.op == OP_NOT || t.op == OP_NEG) begin
        if (stack_count < 1) begin
          expr_error = ST_UNDER;
        end else begin
          a = stack_vals[stack_count-1];
          q = (t.op == OP_NOT) ? ~a : -a;
          if (!stack_flags[stack_count-1]) q[VAL_W-1:8] = '0;
          stack_vals[stack_count-1] = q;
        end
      end else if (t.op >= OP_MUL && t.op <= OP_SHR) begin
        if (stack_count < 2) begin
          expr_error = ST_UNDER;
        end else begin
          a  = stack_vals[stack_count-2];
          fa = stack_flags[stack_count-2];
          b  = stack_vals[stack_count-1];
          fb = stack_flags[stack_count-1];
          case (t.op)
            OP_MUL: q = a * b;
            OP_DIV: q = (b == '0) ? '0 : a / b;
            OP_ADD: q = a + b;
            OP_SUB: q = a - b;
            OP_AND: q = a & b;
            OP_OR:  q = a | b;
            OP_XOR: q = a ^ b;
            OP_SHL: q = (b >= VAL_W) ? '0 : a << b;
            default: q = (b >= VAL_W) ? '0 : a >> b;
          endcase
          if (t.op == OP_DIV && b == '0) begin
            expr_error = ST_DIVZ;
          end else begin
            stack_count--;
            stack_vals[stack_count-1]  = q;
            stack_flags[stack_count-1] = fa | fb;
          end
        end
      end
    end
    if (!t.last) return 1'b0;
    r.status = expr_error;
    if (expr_error == ST_OK && stack_count != 1) r.status = ST_COUNT;
    if (r.status == ST_OK) begin
      r.result = stack_vals[0];
      r.full   = stack_flags[0];
    end
    stack_count = 0;
    expr_error  = ST_OK;
    return 1'b1;
  endfunction

  function automatic table_row_t table_row(input logic [OP_W-1:0] op, input logic [VAL_W-1:0] v,
                                           input logic f, input logic l, input bit typed,
                                           input logic [VAL_W-1:0] rv, input logic rf,
                                           input logic [ST_W-1:0] rs);
    table_row_t row;
    row.tok.op       = op;
    row.tok.value    = v;
    row.tok.full_req = f;
    row.tok.last     = l;
    row.typed        = typed;
    row.want.result  = rv;
    row.want.full    = rf;
    row.want.status  = rs;
    return row;
  endfunction

  // Append one row to the end of the directed table.
  function automatic void add_row(input table_row_t row);
    directed_rows.insert(directed_rows.size(), row);
  endfunction

  // Operand values biased toward extremes and shift amounts.
  function automatic logic [VAL_W-1:0] pick_operand();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      2:       return VAL_W'($urandom_range(20));
      3:       return 16'h8000;
      default: return VAL_W'($urandom);
    endcase
  endfunction

  // Present one token and hold it until the transfer; then update the model.
  task automatic send_token(input token_t t, input bit drain_first, input bit typed,
                            input outcome_t want);
    outcome_t got;
    if (drain_first || $urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
      while (drain_first && pending_results.size() != 0) @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.op       <= t.op;
    in_ch.value    <= t.value;
    in_ch.full_req <= t.full_req;
    in_ch.last     <= t.last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (evaluate_token(t, got))
      pending_results.insert(pending_results.size(), typed ? want : got);
  endtask

  initial begin : result_sink
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin : result_check
    outcome_t oldest;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, got result %h full %b status %0d",
                 $time, out_ch.result, out_ch.result_full, out_ch.status);
        fail_count++;
      end else begin
        oldest = pending_results.pop_front();
        if (out_ch.result !== oldest.result) begin
          $display("%0t: result mismatch: expected %h, got %h",
                   $time, oldest.result, out_ch.result);
          fail_count++;
        end
        if (out_ch.result_full !== oldest.full) begin
          $display("%0t: result_full mismatch: expected %b, got %b",
                   $time, oldest.full, out_ch.result_full);
          fail_count++;
        end
        if (out_ch.status !== oldest.status) begin
          $display("%0t: status mismatch: expected %0d, got %0d",
                   $time, oldest.status, out_ch.status);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("tb_top failed");
      $finish;
    end
  end

  initial begin : stimulus
    token_t   tok;
    outcome_t no_want;
    int       sent, next_phase, phase, depth, pushes_left, unary_left, n, kind;
    bit       drain;

    no_want        = '0;
    in_ch.valid    = 1'b0;
    in_ch.op       = OP_PUSH;
    in_ch.value    = '0;
    in_ch.full_req = 1'b0;
    in_ch.last     = 1'b0;
    rst_n          = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // operator on an empty stack
    add_row(table_row(OP_ADD,  16'h0000, 1'b0, 1'b1, 1, 16'h0000, 1'b0, ST_UNDER));
    // widest multiply wraps
    add_row(table_row(OP_PUSH, 16'hFFFF, 1'b1, 1'b0, 0, 16'h0000, 1'b0, ST_OK));
    add_row(table_row(OP_PUSH, 16'hFFFF, 1'b1, 1'b0, 0, 16'h0000, 1'b0, ST_OK));
    add_row(table_row(OP_MUL,  16'h0000, 1'b0, 1'b1, 1, 16'h0001, 1'b1, ST_OK));
    // divide by zero
    add_row(table_row(OP_PUSH, 16'h0005, 1'b0, 1'b0, 0, 16'h0000, 1'b0, ST_OK));
    add_row(table_row(OP_PUSH, 16'h0000, 1'b0, 1'b0, 0, 16'h0000, 1'b0, ST_OK));
    add_row(table_row(OP_DIV,  16'hFFFF, 1'b1, 1'b1, 1, 16'h0000, 1'b0, ST_DIVZ));
    // short operand keeps its high bits
    add_row(table_row(OP_PUSH, 16'h1234, 1'b0, 1'b1, 1, 16'h1234, 1'b0, ST_OK));
    // shift by the full width
    add_row(table_row(OP_PUSH, 16'h0001, 1'b0, 1'b0, 0, 16'h0000, 1'b0, ST_OK));
    add_row(table_row(OP_PUSH, 16'h0010, 1'b0, 1'b0, 0, 16'h0000, 1'b0, ST_OK));
    add_row(table_row(OP_SHL,  16'h0000, 1'b0, 1'b1, 1, 16'h0000, 1'b0, ST_OK));
    // no-op closing an empty expression
    add_row(table_row(OP_SPARE_LO, 16'hFFFF, 1'b1, 1'b1, 1, 16'h0000, 1'b0, ST_COUNT));
    // mixed chain through the remaining operators
    add_row(table_row(OP_PUSH, 16'hFFFF, 1'b0, 1'b0, 0, 16'h0000, 1'b0, ST_OK));
    add_row(table_row(OP_PUSH, 16'h0001, 1'b0, 1'b0, 0, 16'h0000, 1'b0, ST_OK));
    add_row(table_row(OP_ADD,  16'h0000, 1'b0, 1'b0, 0, 16'h0000, 1'b0, ST_OK));
    add_row(table_row(OP_NEG,  16'h0000, 1'b0, 1'b0, 0, 16'h0000, 1'b0, ST_OK));
    add_row(table_row(OP_PUSH, 16'h0F0F, 1'b1, 1'b0, 0, 16'h0000, 1'b0, ST_OK));
    add_row(table_row(OP_SUB,  16'h0000, 1'b0, 1'b0, 0, 16'h0000, 1'b0, ST_OK));
    add_row(table_row(OP_PUSH, 16'h3C3C, 1'b0, 1'b0, 0, 16'h0000, 1'b0, ST_OK));
    add_row(table_row(OP_AND,  16'h0000, 1'b0, 1'b0, 0, 16'h0000, 1'b0, ST_OK));
    add_row(table_row(OP_NOT,  16'h0000, 1'b0, 1'b0, 0, 16'h0000, 1'b0, ST_OK));
    add_row(table_row(OP_PUSH, 16'h5555, 1'b0, 1'b0, 0, 16'h0000, 1'b0, ST_OK));
    add_row(table_row(OP_XOR,  16'h0000, 1'b0, 1'b0, 0, 16'h0000, 1'b0, ST_OK));
    add_row(table_row(OP_PUSH, 16'h1111, 1'b0, 1'b0, 0, 16'h0000, 1'b0, ST_OK));
    add_row(table_row(OP_OR,   16'h0000, 1'b0, 1'b0, 0, 16'h0000, 1'b0, ST_OK));
    add_row(table_row(OP_PUSH, 16'h0003, 1'b0, 1'b0, 0, 16'h0000, 1'b0, ST_OK));
    add_row(table_row(OP_SHR,  16'h0000, 1'b0, 1'b1, 0, 16'h0000, 1'b0, ST_OK));

    foreach (directed_rows[i])
      send_token(directed_rows[i].tok, 1'b0, directed_rows[i].typed, directed_rows[i].want);

    sent       = 0;
    next_phase = 0;
    phase      = 0;
    while (sent < RANDOM_TOKENS) begin
      drain = 1'b0;
      if (sent >= next_phase) begin
        case (phase % 4)
          0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
          1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
          2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
          default: begin send_idle_pct = 35; recv_stall_pct = 35; end
        endcase
        phase++;
        next_phase += PHASE_TOKENS;
        drain = 1'b1;
      end

      burst.delete();
      kind = $urandom_range(9);
      if (kind < 7) begin
        // well-formed expression, depth stays below the stack size
        pushes_left = $urandom_range(1, 9);
        unary_left  = $urandom_range(2);
        depth       = 0;
        while (pushes_left > 0 || depth > 1) begin
          tok.value    = pick_operand();
          tok.full_req = 1'($urandom_range(1));
          tok.last     = 1'b0;
          if (pushes_left > 0 && (depth < 2 || $urandom_range(1) == 1)) begin
            tok.op = OP_PUSH;
            pushes_left--;
            depth++;
          end else if (unary_left > 0 && $urandom_range(4) == 0) begin
            tok.op = $urandom_range(1) ? OP_NOT : OP_NEG;
            unary_left--;
          end else begin
            tok.op = OP_W'($urandom_range(OP_MUL, OP_SHR));
            depth--;
          end
          burst.insert(burst.size(), tok);
        end
      end else if (kind == 7) begin
        // fill the stack close to, up to or past its depth, then reduce
        n = $urandom_range(14, 18);
        for (int i = 0; i < 2 * n - 1; i++) begin
          tok.value    = pick_operand();
          tok.full_req = 1'($urandom_range(1));
          tok.last     = 1'b0;
          tok.op       = (i < n) ? OP_PUSH : OP_W'($urandom_range(OP_MUL, OP_SHR));
          burst.insert(burst.size(), tok);
        end
      end else begin
        // raw tokens: any opcode, stray last flags
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++) begin
          tok.op       = OP_W'($urandom_range(OP_SPARE_HI));
          tok.value    = VAL_W'($urandom);
          tok.full_req = 1'($urandom_range(1));
          tok.last     = ($urandom_range(5) == 0);
          burst.insert(burst.size(), tok);
        end
      end
      tok      = burst.pop_back();
      tok.last = 1'b1;
      burst.insert(burst.size(), tok);

      foreach (burst[i]) send_token(burst[i], drain && i == 0, 1'b0, no_want);
      sent += burst.size();
    end

    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0)
      $display("tb_top passed");
    else
      $display("tb_top failed");
    $finish;
  end

endmodule

`default_nettype wire
